// ===== design/wsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfe_pkg
// Shared types and constants for the WebSocket frame encoder.
// ----------------------------------------------------------------------------
package wsfe_pkg;

	localparam int unsigned LEN_W   = 63;
	localparam int unsigned KEY_W   = 32;
	localparam int unsigned HDR_MAX = 14;
	localparam int unsigned IDX_W   = 4;

	typedef logic [LEN_W-1:0] len_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [KEY_W-1:0] key_t;

	// item kinds
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_DATA  = 1'b1;

	// opcodes
	localparam logic [3:0] OP_CONT  = 4'd0;
	localparam logic [3:0] OP_CLOSE = 4'd8;
	localparam logic [3:0] OP_PING  = 4'd9;
	localparam logic [3:0] OP_PONG  = 4'd10;

	// length codes and form limits
	localparam logic [6:0] LEN_CODE16  = 7'd126;
	localparam logic [6:0] LEN_CODE64  = 7'd127;
	localparam len_t       LEN7_LIMIT  = 63'd126;
	localparam len_t       LEN16_LIMIT = 63'd65536;

	typedef struct packed {
		logic [HDR_MAX-1:0][7:0] bytes;
		idx_t                    last_idx;
	} hdr_t;

	typedef struct packed {
		logic       func;
		hdr_t       hdr;
		key_t       key;
		logic       mask_on;
		len_t       len;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_header;
		logic       last;
		logic       frame_end;
		logic       overrun;
	} res_t;

endpackage

// ===== design/wsfe_item_if.sv =====
// ----------------------------------------------------------------------------
// wsfe_item_if
// Input channel: start items and payload bytes.
// ----------------------------------------------------------------------------
interface wsfe_item_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [3:0]  opcode;
	logic        fin;
	logic        mask_on;
	logic [31:0] frame_key;
	logic [62:0] frame_len;
	logic [7:0]  data_byte;

	modport source (output valid, func, opcode, fin, mask_on, frame_key,
		frame_len, data_byte, input ready);
	modport sink (input valid, func, opcode, fin, mask_on, frame_key,
		frame_len, data_byte, output ready);
endinterface

// ===== design/wsfe_byte_if.sv =====
// ----------------------------------------------------------------------------
// wsfe_byte_if
// Output channel: encoded frame bytes.
// ----------------------------------------------------------------------------
interface wsfe_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_header;
	logic       last;
	logic       frame_end;
	logic       overrun;

	modport source (output valid, out_byte, is_header, last, frame_end, overrun,
		input ready);
	modport sink (input valid, out_byte, is_header, last, frame_end, overrun,
		output ready);
endinterface

// ===== design/wsfe_hdr.sv =====
// ----------------------------------------------------------------------------
// wsfe_hdr
// Builds the complete header byte run (up to 14 bytes) for a start item.
// ----------------------------------------------------------------------------
module wsfe_hdr import wsfe_pkg::*; (
	input  logic [3:0] opcode,
	input  logic       fin,
	input  logic       mask_on,
	input  key_t       frame_key,
	input  len_t       frame_len,
	output hdr_t       hdr
);

	logic                 fin_eff;
	logic [3:0]           opc_eff;
	idx_t                 key_base;
	logic [LEN_W:0]       ext_len;

	assign ext_len = {1'b0, frame_len};

	always_comb begin
		// control frames are always final; non-final data frames continue
		priority if (opcode == OP_CLOSE || opcode == OP_PING || opcode == OP_PONG) begin
			fin_eff = 1'b1;
			opc_eff = opcode;
		end else if (!fin) begin
			fin_eff = 1'b0;
			opc_eff = OP_CONT;
		end else begin
			fin_eff = 1'b1;
			opc_eff = opcode;
		end

		hdr.bytes    = '0;
		hdr.bytes[0] = {fin_eff, 3'b000, opc_eff};

		priority if (frame_len < LEN7_LIMIT) begin
			hdr.bytes[1] = {mask_on, frame_len[6:0]};
			key_base     = idx_t'(2);
		end else if (frame_len < LEN16_LIMIT) begin
			hdr.bytes[1] = {mask_on, LEN_CODE16};
			hdr.bytes[2] = frame_len[15:8];
			hdr.bytes[3] = frame_len[7:0];
			key_base     = idx_t'(4);
		end else begin
			hdr.bytes[1] = {mask_on, LEN_CODE64};
			for (int k = 0; k < 8; k++) begin
				hdr.bytes[2+k] = ext_len[8*(7-k) +: 8];
			end
			key_base     = idx_t'(10);
		end

		if (mask_on) begin
			for (int k = 0; k < 4; k++) begin
				hdr.bytes[key_base + idx_t'(k)] = frame_key[8*k +: 8];
			end
			hdr.last_idx = key_base + idx_t'(3);
		end else begin
			hdr.last_idx = key_base - idx_t'(1);
		end
	end

endmodule

// ===== design/wsfe_core.sv =====
// ----------------------------------------------------------------------------
// wsfe_core
// Frame state, byte sequencing and the result register.
// ----------------------------------------------------------------------------
module wsfe_core import wsfe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s1_valid,
	input  item_t s1,
	output logic  s1_done,
	input  logic  out_ready,
	output logic  out_valid,
	output res_t  res
);

	key_t       held_key_q;
	logic       mask_active_q;
	logic [1:0] key_phase_q;
	len_t       bytes_left_q;
	idx_t       idx_q;
	logic       out_valid_q;
	res_t       res_q;

	logic       emit;
	logic       item_last;
	logic       ovr;
	logic [7:0] key_byte;
	res_t       nxt;

	assign emit     = s1_valid && (!out_valid_q || out_ready);
	assign ovr      = (bytes_left_q == '0);
	assign key_byte = mask_active_q ? held_key_q[{key_phase_q, 3'b000} +: 8] : 8'h00;

	always_comb begin
		unique case (s1.func)
			FUNC_DATA: begin
				item_last     = 1'b1;
				nxt.out_byte  = ovr ? s1.data : (s1.data ^ key_byte);
				nxt.is_header = 1'b0;
				nxt.last      = 1'b1;
				nxt.frame_end = (bytes_left_q == len_t'(1));
				nxt.overrun   = ovr;
			end
			default: begin
				item_last     = (idx_q == s1.hdr.last_idx);
				nxt.out_byte  = s1.hdr.bytes[idx_q];
				nxt.is_header = 1'b1;
				nxt.last      = item_last;
				nxt.frame_end = item_last && (s1.len == '0);
				nxt.overrun   = 1'b0;
			end
		endcase
	end

	assign s1_done = emit && item_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_key_q    <= '0;
			mask_active_q <= 1'b0;
			key_phase_q   <= '0;
			bytes_left_q  <= '0;
			idx_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				idx_q       <= item_last ? '0 : idx_q + idx_t'(1);
				if (s1.func == FUNC_DATA) begin
					if (!ovr) begin
						key_phase_q  <= key_phase_q + 2'd1;
						bytes_left_q <= bytes_left_q - len_t'(1);
					end
				end else if (idx_q == '0) begin
					// start item reloads the frame state on its first byte
					held_key_q    <= s1.key;
					mask_active_q <= s1.mask_on;
					key_phase_q   <= '0;
					bytes_left_q  <= s1.len;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

// ===== design/websocket_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_encoder
// WebSocket frame header builder and payload masker, byte-stream output.
// ----------------------------------------------------------------------------
// Path: an input transfer is registered in the stage 1 input register, then in the result register.
// Throughput: payload items go out one per cycle; a start item sends its header bytes
//   (2, 4, 6, 8, 10 or 14) one per cycle over the single output byte lane; output stalls hold both.
// Reset: arst_n clears the frame state, the sequencer and both valid flags;
//   data registers are not reset.
// ----------------------------------------------------------------------------
module websocket_frame_encoder import wsfe_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	wsfe_item_if.sink   item,
	wsfe_byte_if.source stream
);

	// Stage 1: input register. The full header run is built on the way in,
	// so the sequencer only has to pick one byte a cycle.
	logic  valid_s1;
	item_t item_s1;
	hdr_t  hdr_in;
	logic  s1_done;
	logic  accept;
	res_t  res;

	wsfe_hdr u_hdr (
		.opcode    (item.opcode),
		.fin       (item.fin),
		.mask_on   (item.mask_on),
		.frame_key (item.frame_key),
		.frame_len (item.frame_len),
		.hdr       (hdr_in)
	);

	// Stage 1 frees up in the same cycle its item sends its last byte,
	// so payload bytes stream one per cycle while the output is not stalled.
	assign item.ready = !valid_s1 || s1_done;
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.func    <= item.func;
			item_s1.hdr     <= hdr_in;
			item_s1.key     <= item.frame_key;
			item_s1.mask_on <= item.mask_on;
			item_s1.len     <= item.frame_len;
			item_s1.data    <= item.data_byte;
		end
	end

	// Stage 2: state update, masking and the result register.
	wsfe_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (valid_s1),
		.s1        (item_s1),
		.s1_done   (s1_done),
		.out_ready (stream.ready),
		.out_valid (stream.valid),
		.res       (res)
	);

	assign stream.out_byte  = res.out_byte;
	assign stream.is_header = res.is_header;
	assign stream.last      = res.last;
	assign stream.frame_end = res.frame_end;
	assign stream.overrun   = res.overrun;

endmodule

// ===== design/wsfe_checker.sv =====
// ----------------------------------------------------------------------------
// wsfe_checker
// Port-level checks on the encoded byte stream.
// ----------------------------------------------------------------------------
module wsfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       is_header,
	input logic       last,
	input logic       frame_end,
	input logic       overrun
);

	// set while a header run is partly transferred
	logic hdr_run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_run_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			hdr_run_q <= is_header && !last;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(last) && $stable(is_header))
		else $error("output changed while stalled");

	a_hdr_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hdr_run_q |-> is_header)
		else $error("header run broken by payload byte");

	a_payload_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_header |-> last)
		else $error("payload byte not marked last");

	a_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overrun |-> !is_header && !frame_end)
		else $error("overrun on header or frame end");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> last && !overrun)
		else $error("frame end without last");

endmodule

bind websocket_frame_encoder wsfe_checker u_wsfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (stream.valid),
	.out_ready (stream.ready),
	.out_byte  (stream.out_byte),
	.is_header (stream.is_header),
	.last      (stream.last),
	.frame_end (stream.frame_end),
	.overrun   (stream.overrun)
);

// ===== bench/websocket_frame_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_encoder_tb
// Self-checking bench for the WebSocket frame encoder. Start and payload
// items go in with random gaps, and encoded bytes come out against random
// backpressure. A scoreboard predicts every output byte from the accepted
// items and compares each transfer field by field.
// ----------------------------------------------------------------------------
module websocket_frame_encoder_tb import wsfe_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RAND_ITEMS  = 300;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 400;  // long output stall
	localparam int unsigned DRAIN_WAIT  = 20;   // settle time after the scoreboard drains
	localparam int unsigned MAX_REPORTS = 10;

	// ------------------------------------------------------------------------
	// Frame scoreboard: mirrors the encoder state and keeps the bytes that
	// should come out, oldest first.
	// ------------------------------------------------------------------------
	class frame_scoreboard;
		res_t        pending[$];
		key_t        key;
		logic        masked;
		logic [1:0]  phase;
		len_t        remaining;
		int unsigned errors;

		function new();
			key       = '0;
			masked    = 1'b0;
			phase     = '0;
			remaining = '0;
			errors    = 0;
		endfunction

		function void push(logic [7:0] b, logic hdr, logic lst, logic fend, logic ovr);
			res_t r;
			r.out_byte  = b;
			r.is_header = hdr;
			r.last      = lst;
			r.frame_end = fend;
			r.overrun   = ovr;
			pending.push_back(r);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endfunction

		// work out the bytes one accepted item causes
		function void note_item(logic func, logic [3:0] opc, logic fin, logic mon,
				key_t k, len_t len, logic [7:0] data);
			logic [7:0]  hb[HDR_MAX];
			logic [63:0] wide;
			logic [7:0]  b;
			int          n;
			if (func == FUNC_DATA) begin
				if (remaining == '0) begin
					// past the stated length: raw byte, state untouched
					push(data, 1'b0, 1'b1, 1'b0, 1'b1);
				end else begin
					b = masked ? (data ^ key[{phase, 3'b000} +: 8]) : data;
					phase     = phase + 2'd1;
					remaining = remaining - len_t'(1);
					push(b, 1'b0, 1'b1, remaining == '0, 1'b0);
				end
				return;
			end
			// control frames are always final; a non-final frame goes out as continuation
			if (opc == OP_CLOSE || opc == OP_PING || opc == OP_PONG)
				fin = 1'b1;
			else if (!fin)
				opc = OP_CONT;
			hb[0] = {fin, 3'b000, opc};
			if (len < LEN7_LIMIT) begin
				hb[1] = {mon, len[6:0]};
				n = 2;
			end else if (len < LEN16_LIMIT) begin
				hb[1] = {mon, LEN_CODE16};
				hb[2] = len[15:8];
				hb[3] = len[7:0];
				n = 4;
			end else begin
				hb[1] = {mon, LEN_CODE64};
				wide = {1'b0, len};
				n = 2;
				for (int i = 7; i >= 0; i--) begin
					hb[n] = wide[8*i +: 8];
					n++;
				end
			end
			if (mon) begin
				for (int i = 0; i < 4; i++) begin
					hb[n] = k[8*i +: 8];
					n++;
				end
			end
			key       = k;
			masked    = mon;
			phase     = '0;
			remaining = len;
			for (int i = 0; i < n; i++)
				push(hb[i], 1'b1, i == n - 1, (i == n - 1) && (len == '0), 1'b0);
		endfunction

		function void check(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				flag($sformatf("byte %02h with nothing expected", got.out_byte));
				return;
			end
			want = pending.pop_front();
			if (got.out_byte !== want.out_byte)
				flag($sformatf("out_byte exp %02h got %02h", want.out_byte, got.out_byte));
			if (got.is_header !== want.is_header)
				flag($sformatf("is_header exp %b got %b", want.is_header, got.is_header));
			if (got.last !== want.last)
				flag($sformatf("last exp %b got %b", want.last, got.last));
			if (got.frame_end !== want.frame_end)
				flag($sformatf("frame_end exp %b got %b", want.frame_end, got.frame_end));
			if (got.overrun !== want.overrun)
				flag($sformatf("overrun exp %b got %b", want.overrun, got.overrun));
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels, DUT
	// ------------------------------------------------------------------------
	logic clk;
	logic arst_n;

	wsfe_item_if item_ch();
	wsfe_byte_if byte_ch();

	websocket_frame_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.stream (byte_ch)
	);

	frame_scoreboard sb = new();

	int unsigned sent;    // input transfers so far
	int unsigned beats;   // output transfers so far
	int unsigned cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Monitors: both channels sampled on the same edge the DUT sees.
	// An input can't produce output in its own cycle, so order doesn't matter.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				sb.note_item(item_ch.func, item_ch.opcode, item_ch.fin, item_ch.mask_on,
					item_ch.frame_key, item_ch.frame_len, item_ch.data_byte);
			if (byte_ch.valid && byte_ch.ready)
				sb.check('{out_byte: byte_ch.out_byte, is_header: byte_ch.is_header,
					last: byte_ch.last, frame_end: byte_ch.frame_end,
					overrun: byte_ch.overrun});
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Output side: random stall before each transfer, calm stretches every
	// third block of 50, and one long hold-off mid-run so the encoder backs up
	// and drops item.ready while the sender keeps offering.
	// ------------------------------------------------------------------------
	initial begin
		int unsigned stall;
		bit          held;
		held = 1'b0;
		byte_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && sent >= 150) begin
				held = 1'b1;
				byte_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = (((beats / 50) % 3) == 1) ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				byte_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			byte_ch.ready <= 1'b1;
			do @(posedge clk); while (!byte_ch.valid);
			beats++;
		end
	end

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------

	// One transfer. Called at a clock edge; returns at the edge it is taken.
	// valid stays high across back-to-back items, so it is never lowered and
	// raised in the same step.
	task automatic send_item(logic func, logic [3:0] opc, logic fin, logic mon,
			key_t k, len_t len, logic [7:0] data);
		int unsigned gap;
		gap = (((sent / 40) % 3) == 2) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.func      <= func;
		item_ch.opcode    <= opc;
		item_ch.fin       <= fin;
		item_ch.mask_on   <= mon;
		item_ch.frame_key <= k;
		item_ch.frame_len <= len;
		item_ch.data_byte <= data;
		do @(posedge clk); while (!item_ch.ready);
		sent++;
	endtask

	function automatic len_t rand_len63();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[62:0];
	endfunction

	// payload transfer; header fields carry junk since the DUT ignores them
	task automatic send_byte(logic [7:0] data);
		send_item(FUNC_DATA, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), $urandom(), rand_len63(), data);
	endtask

	task automatic send_start(logic [3:0] opc, logic fin, logic mon, key_t k, len_t len);
		send_item(FUNC_START, opc, fin, mon, k, len, 8'($urandom_range(0, 255)));
	endtask

	// One random frame: start, then the right byte count for most short lengths,
	// else short (next start abandons it) or long (trailing bytes overrun).
	task automatic random_frame();
		int unsigned pick;
		len_t        len;
		int unsigned n;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			len = len_t'($urandom_range(0, 20));
		else if (pick < 72)
			len = len_t'($urandom_range(110, 140));    // around the 16-bit code
		else if (pick < 82)
			len = len_t'($urandom_range(0, 65535));
		else if (pick < 90)
			len = len_t'($urandom_range(65530, 65541)); // around the 64-bit code
		else
			len = rand_len63();

		// stray payload byte between frames
		if ($urandom_range(0, 19) == 0)
			send_byte(8'($urandom_range(0, 255)));

		send_start(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 3) != 0), $urandom(), len);

		if (len > len_t'(24)) begin
			n = $urandom_range(0, 6);
		end else begin
			n = int'(len);
			pick = $urandom_range(0, 99);
			if (pick < 15)
				n = n + $urandom_range(1, 3);
			else if (pick < 25)
				n = $urandom_range(0, n);
		end
		repeat (n) send_byte(8'($urandom_range(0, 255)));
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int unsigned target;
		cycles <= 0;
		sent = 0;
		beats = 0;
		arst_n            <= 1'b0;
		item_ch.valid     <= 1'b0;
		item_ch.func      <= FUNC_START;
		item_ch.opcode    <= OP_CONT;
		item_ch.fin       <= 1'b0;
		item_ch.mask_on   <= 1'b0;
		item_ch.frame_key <= '0;
		item_ch.frame_len <= '0;
		item_ch.data_byte <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// payload before any frame: raw byte with overrun
		send_byte(8'hA5);
		// empty unmasked frame: two header bytes, frame_end on the second
		send_start(4'd1, 1'b1, 1'b0, 32'h0, '0);
		send_byte(8'h00);
		// fin low: opcode turns into continuation; largest 7-bit length
		send_start(4'd2, 1'b0, 1'b1, 32'hDEADBEEF, len_t'(125));
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h5A);
		send_byte(8'hC3);
		send_byte(8'h81);
		// new start mid-frame; close with fin low still goes out final
		send_start(OP_CLOSE, 1'b0, 1'b1, 32'h01234567, len_t'(126));
		// ping, largest 16-bit length
		send_start(OP_PING, 1'b0, 1'b0, 32'hFFFFFFFF, len_t'(65535));
		// pong, smallest 64-bit length: longest masked header
		send_start(OP_PONG, 1'b1, 1'b1, 32'h80000001, len_t'(65536));
		// unassigned opcode with the largest length
		send_start(4'd3, 1'b1, 1'b1, 32'hFFFFFFFF, {LEN_W{1'b1}});
		// unassigned opcode, fin low: continuation, empty frame
		send_start(4'd15, 1'b0, 1'b0, 32'h0, '0);
		// short masked frame run to the end, then one byte too many
		send_start(4'd7, 1'b1, 1'b1, 32'h04030201, len_t'(5));
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h10);
		send_byte(8'h20);
		send_byte(8'h30);
		send_byte(8'h40);
		// unmasked text frame completed exactly
		send_start(4'd1, 1'b1, 1'b0, 32'h55AA55AA, len_t'(2));
		send_byte(8'h7E);
		send_byte(8'h81);

		// --- random frames ---
		target = sent + RAND_ITEMS;
		while (sent < target)
			random_frame();
		item_ch.valid <= 1'b0;

		// drain, then a short settle for anything unexpected
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (sb.pending.size() != 0)
			sb.flag($sformatf("%0d bytes never arrived", sb.pending.size()));
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== websocket_frame_encoder.f =====
design/wsfe_pkg.sv
design/wsfe_item_if.sv
design/wsfe_byte_if.sv
design/wsfe_hdr.sv
design/wsfe_core.sv
design/websocket_frame_encoder.sv
design/wsfe_checker.sv
bench/websocket_frame_encoder_tb.sv
